### rtl/murmur2_string_hash_core_assert.svh
`ifndef MURMUR2_STRING_HASH_CORE_ASSERT_SVH
`define MURMUR2_STRING_HASH_CORE_ASSERT_SVH

// Assertion macros for the hash core. Define ASSERT_OFF to remove them.

`ifndef ASSERT_OFF

`define MSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MSH_ASSERT(lbl, prop, msg)

`define MSH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/msh_pkg.sv
`timescale 1ns / 1ps

package msh_pkg;

  localparam logic [31:0] MIX_M      = 32'h5bd1e995;
  localparam int          MIX_R      = 24;
  localparam int          FIN_A      = 13;
  localparam int          FIN_B      = 15;
  localparam logic [31:0] SEED_RESET = 32'h31415926;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_H,
    ST_T,
    ST_F
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_K1,
    MUL_K2,
    MUL_H,
    MUL_T,
    MUL_F
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    use_seed;
    mul_op_t op;
    logic    fin_write;
  } ctrl_cmd_t;

endpackage

### rtl/msh_ctrl.sv
`timescale 1ns / 1ps

`include "murmur2_string_hash_core_assert.svh"

module msh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_byte_count,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output msh_pkg::ctrl_cmd_t cmd
);

  msh_pkg::state_t state_r, state_nxt;
  logic            last_r, last_nxt;
  logic            in_msg_r, in_msg_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;

  assign in_stall  = (state_r != msh_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msh_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_byte_count[2]) begin
            state_nxt = msh_pkg::ST_K1;
          end else if (in_byte_count[1:0] != 2'd0) begin
            state_nxt = msh_pkg::ST_T;
          end else if (in_last) begin
            state_nxt = msh_pkg::ST_F;
          end
        end
      end
      msh_pkg::ST_K1: state_nxt = msh_pkg::ST_K2;
      msh_pkg::ST_K2: state_nxt = msh_pkg::ST_H;
      msh_pkg::ST_H,
      msh_pkg::ST_T: begin
        state_nxt = last_r ? msh_pkg::ST_F : msh_pkg::ST_IDLE;
      end
      msh_pkg::ST_F: begin
        if (out_free) begin
          state_nxt = msh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = msh_pkg::MUL_NONE;
    last_nxt      = last_r;
    in_msg_nxt    = in_msg_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      msh_pkg::ST_IDLE: begin
        cmd.load     = accept;
        cmd.use_seed = !in_msg_r;
        if (accept) begin
          last_nxt   = in_last;
          in_msg_nxt = !in_last;
        end
      end
      msh_pkg::ST_K1: cmd.op = msh_pkg::MUL_K1;
      msh_pkg::ST_K2: cmd.op = msh_pkg::MUL_K2;
      msh_pkg::ST_H:  cmd.op = msh_pkg::MUL_H;
      msh_pkg::ST_T:  cmd.op = msh_pkg::MUL_T;
      msh_pkg::ST_F: begin
        cmd.op        = msh_pkg::MUL_F;
        cmd.fin_write = out_free;
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = msh_pkg::MUL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msh_pkg::ST_IDLE;
      last_r      <= 1'b0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MSH_ASSERT(a_full_word_mixes, (accept && in_byte_count[2]) |=> (state_r == msh_pkg::ST_K1), "full word did not start mixing")
  `MSH_ASSERT(a_result_from_final, $rose(out_valid_r) |-> ($past(state_r) == msh_pkg::ST_F), "result word raised outside finalization")
  `MSH_ASSERT(a_final_waits, (state_r == msh_pkg::ST_F && out_valid_r && out_stall) |=> (state_r == msh_pkg::ST_F), "finalization overwrote a pending result")
  `MSH_ASSERT(a_last_ends_message, (accept && in_last) |=> !in_msg_r, "message still open after last word")

endmodule

### rtl/msh_datapath.sv
`timescale 1ns / 1ps

module msh_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  msh_pkg::ctrl_cmd_t cmd,
  input  logic [31:0]        in_data_word,
  input  logic [2:0]         in_byte_count,
  input  logic [15:0]        in_total_length,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output logic [31:0]        out_hash
);

  logic [31:0] seed_r;
  logic [31:0] word_r;
  logic [1:0]  tail_r;
  logic [31:0] h_r;
  logic [31:0] acc_r;
  logic [31:0] out_hash_r;
  logic [31:0] tail_mask;
  logic [31:0] mul_opnd;
  logic [31:0] product;

  always_comb begin
    case (tail_r)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    case (cmd.op)
      msh_pkg::MUL_K1: mul_opnd = word_r;
      msh_pkg::MUL_K2: mul_opnd = acc_r ^ (acc_r >> msh_pkg::MIX_R);
      msh_pkg::MUL_H:  mul_opnd = h_r;
      msh_pkg::MUL_T:  mul_opnd = h_r ^ (word_r & tail_mask);
      msh_pkg::MUL_F:  mul_opnd = h_r ^ (h_r >> msh_pkg::FIN_A);
      default:         mul_opnd = h_r;
    endcase
  end

  assign product  = 32'(mul_opnd * msh_pkg::MIX_M);
  assign out_hash = out_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= msh_pkg::SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_data_word;
      tail_r <= in_byte_count[1:0];
      if (cmd.use_seed) begin
        h_r <= seed_r ^ {16'd0, in_total_length};
      end
    end
    case (cmd.op)
      msh_pkg::MUL_K1,
      msh_pkg::MUL_K2: acc_r <= product;
      msh_pkg::MUL_H:  h_r   <= product ^ acc_r;
      msh_pkg::MUL_T:  h_r   <= product;
      default: ;
    endcase
    if (cmd.fin_write) begin
      out_hash_r <= product ^ (product >> msh_pkg::FIN_B);
    end
  end

endmodule

### rtl/murmur2_string_hash_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                                   Direction
// input     in_valid in_stall in_data_word in_byte_count             in
//           in_last in_total_length
// result    out_valid out_stall out_hash                             out
// config    cfg_wr_en cfg_wr_data                                    in
//
// One shared 32-bit multiplier by the mixing constant sets the timing.
// A full word passes through the states K1, K2 and H, a word of 1 to 3 bytes through T, a word of no bytes neither.
// A last word adds the finalization state F, held while an earlier hash still waits.
// Synchronous active-low reset closes any open message and sets the seed to 0x31415926.
// A new word is taken while a finished hash waits in the output register.

module murmur2_string_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  input  logic [15:0] in_total_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  msh_pkg::ctrl_cmd_t cmd;

  msh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  msh_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_total_length (in_total_length),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_hash        (out_hash)
  );

endmodule

### sim/murmur2_string_hash_checker.sv
`timescale 1ns / 1ps

module murmur2_string_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  input  logic [15:0] in_total_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_hash,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

  logic [31:0] seed_q;
  logic [31:0] partial_hash;
  logic        msg_open;
  logic [31:0] expected_hashes[$];
  int          mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  function automatic logic [31:0] absorb_word(logic [31:0] h, logic [31:0] k);
    logic [31:0] mixed;
    mixed = k * msh_pkg::MIX_M;
    mixed = mixed ^ (mixed >> msh_pkg::MIX_R);
    mixed = mixed * msh_pkg::MIX_M;
    h = h * msh_pkg::MIX_M;
    return h ^ mixed;
  endfunction

  function automatic logic [31:0] absorb_tail(logic [31:0] h, logic [31:0] w,
                                              logic [2:0] n);
    logic [31:0] kept;
    case (n)
      3'd1:    kept = w & 32'h0000_00ff;
      3'd2:    kept = w & 32'h0000_ffff;
      default: kept = w & 32'h00ff_ffff;
    endcase
    h = h ^ kept;
    return h * msh_pkg::MIX_M;
  endfunction

  function automatic logic [31:0] avalanche_hash(logic [31:0] h);
    h = h ^ (h >> msh_pkg::FIN_A);
    h = h * msh_pkg::MIX_M;
    h = h ^ (h >> msh_pkg::FIN_B);
    return h;
  endfunction

  always @(posedge clk) begin
    logic [31:0] h;
    logic [31:0] want;
    logic [2:0]  n;
    if (!rst_n) begin
      seed_q       = msh_pkg::SEED_RESET;
      partial_hash = '0;
      msg_open     = 1'b0;
      expected_hashes.delete();
    end else begin
      if (cfg_wr_en) begin
        seed_q = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected hash %h with nothing outstanding.", out_hash);
          end
        end else begin
          want = expected_hashes.pop_front();
          if (out_hash !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Hash mismatch: expected %h, got %h.", want, out_hash);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        n = (in_byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : in_byte_count;
        h = msg_open ? partial_hash : (seed_q ^ {16'h0000, in_total_length});
        if (n == FULL_WORD_BYTES) begin
          h = absorb_word(h, in_data_word);
        end else if (n != 3'd0) begin
          h = absorb_tail(h, in_data_word, n);
        end
        if (in_last) begin
          partial_hash = '0;
          msg_open     = 1'b0;
          expected_hashes.push_back(avalanche_hash(h));
        end else begin
          partial_hash = h;
          msg_open     = 1'b1;
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_hashes.size();
  end

endmodule

### sim/tb_murmur2_string_hash_core.sv
`timescale 1ns / 1ps

module tb_murmur2_string_hash_core;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_WORDS    = 215;
  localparam int NUM_PHASES     = 6;
  localparam int PRESSURE_PHASE = 3;
  localparam int CARRY_PHASE    = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last = 1'b0;
  logic [15:0] in_total_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  int fail_count;
  int pending;
  int words_sent = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_requests = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  murmur2_string_hash_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .in_total_length (in_total_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash        (out_hash),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  murmur2_string_hash_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .in_total_length (in_total_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash        (out_hash),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // The receiver stalls in segments of random style, and holds off for a long
  // stretch whenever the stimulus asks for it.
  initial begin
    int seg_left;
    int style;
    int hold_left;
    int holds_served;
    seg_left     = 0;
    style        = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        style    = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= seg_left[2];
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL murmur2_string_hash_core");
    $finish;
  end

  task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic lst,
                           input logic [15:0] len);
    in_valid        <= 1'b1;
    in_data_word    <= w;
    in_byte_count   <= n;
    in_last         <= lst;
    in_total_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0 && !no_gaps) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_message(input bit noisy);
    int          len;
    int          nwords;
    int          pick;
    logic [15:0] len_field;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      len = $urandom_range(0, 16);
    end else if (pick < 18) begin
      len = $urandom_range(17, 64);
    end else begin
      len = $urandom_range(65, 200);
    end
    nwords    = (len == 0) ? 1 : (len + 3) / 4;
    len_field = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(len);
    for (int i = 0; i < nwords; i++) begin
      bit         lst;
      logic [2:0] n;
      lst = (i == nwords - 1);
      n   = lst ? 3'(len - 4 * i) : 3'd4;
      if (n == 3'd4 && $urandom_range(0, 7) == 0) begin
        n = 3'($urandom_range(5, 7));
      end
      if (!lst && noisy && $urandom_range(0, 3) == 0) begin
        n = 3'($urandom_range(0, 3));
      end
      send_word($urandom, n, lst, (i == 0) ? len_field : 16'($urandom));
    end
  endtask

  task automatic settle();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [31:0] seeds [NUM_PHASES];
    int          phase_start;
    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hffff_ffff;
    for (int s = 2; s < NUM_PHASES; s++) begin
      seeds[s] = $urandom;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short messages at the edges of the fields, under the reset seed.
    no_gaps = 1'b1;
    send_word($urandom, 3'd0, 1'b1, 16'd0);
    send_word(32'hffff_ffff, 3'd1, 1'b1, 16'd1);
    send_word(32'h0000_0000, 3'd2, 1'b1, 16'd2);
    send_word($urandom, 3'd3, 1'b1, 16'd3);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 16'd4);
    send_word(32'h0000_0000, 3'd4, 1'b0, 16'hffff);
    send_word($urandom, 3'd1, 1'b1, 16'hffff);
    no_gaps = 1'b0;
    send_word($urandom, 3'd5, 1'b0, 16'd12);
    send_word($urandom, 3'd6, 1'b0, 16'hffff);
    send_word($urandom, 3'd7, 1'b1, 16'd0);
    send_word($urandom, 3'd2, 1'b0, 16'd9);
    send_word($urandom, 3'd3, 1'b0, 16'h0000);
    send_word($urandom, 3'd4, 1'b1, 16'h1234);
    send_word($urandom, 3'd0, 1'b0, 16'hffff);
    send_word($urandom, 3'd0, 1'b0, 16'h0000);
    send_word($urandom, 3'd1, 1'b1, 16'h5555);
    send_word(32'haaaa_5555, 3'd4, 1'b0, 16'h0003);
    send_word(32'h5555_aaaa, 3'd4, 1'b0, 16'haaaa);
    send_word($urandom, 3'd4, 1'b1, 16'h5555);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_seed(seeds[p]);
      burst_left  = 0;
      no_gaps     = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      phase_start = words_sent;
      if (p == PRESSURE_PHASE) begin
        hold_requests <= hold_requests + 1;
      end
      while (words_sent - phase_start < PHASE_WORDS) begin
        send_message($urandom_range(0, 4) == 0);
      end
      // This phase leaves a message open so that the next seed write lands
      // in the middle of it.
      if (p == CARRY_PHASE) begin
        send_word($urandom, 3'd4, 1'b0, 16'($urandom));
        send_word($urandom, 3'd4, 1'b0, 16'($urandom));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS murmur2_string_hash_core");
    end else begin
      $display("FAIL murmur2_string_hash_core");
    end
    $finish;
  end

endmodule
